[rtl/lock_waiter_wakeup_table_top_assert.svh]
// assertion macros shared by the lock waiter wake-up table checker
`ifndef LOCK_WAITER_WAKEUP_TABLE_TOP_ASSERT_SVH
`define LOCK_WAITER_WAKEUP_TABLE_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LWWT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LWWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lwwt_pkg.sv]
// types, codes and defaults for the lock waiter wake-up table
`default_nettype none

package lwwt_pkg;

  // default sizes
  localparam int NUM_PROCS_DEF = 16;
  localparam int ADDR_BITS_DEF = 32;

  // reset value of the active processor register
  localparam logic [4:0] ACTIVE_PROCS_RST = 5'd16;

  // stall status codes
  localparam logic [1:0] STAT_BUSY  = 2'd0;
  localparam logic [1:0] STAT_SYNCH = 2'd1;

  // event codes
  typedef enum logic [3:0] {
    OP_START       = 4'd0,
    OP_EXIT        = 4'd1,
    OP_RESUME      = 4'd2,
    OP_STOP        = 4'd3,
    OP_LOCK_WAIT   = 4'd4,
    OP_WAKE_ONE    = 4'd5,
    OP_WAKE_ALL    = 4'd6,
    OP_ENTER_SYNCH = 4'd7,
    OP_LEAVE_SYNCH = 4'd8
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // request beat
  typedef struct packed {
    logic [3:0]  opcode;
    logic [3:0]  proc_id;
    logic [1:0]  stop_status;
    logic [31:0] lock_address;
  } req_t;

  // response beat
  typedef struct packed {
    logic       woke_valid;
    logic [3:0] woke_proc;
    logic       sim_ended;
    logic [4:0] running_count;
  } rsp_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic ready;
    logic issue;
    logic check;
    logic wake_one;
    logic finish;
  } scan_ctl_t;

endpackage

`default_nettype wire

[rtl/lwwt_ram.sv]
// generic single write, single read ram with registered read data
`default_nettype none

module lwwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/lwwt_seq.sv]
// sequencer for the round-robin address scan of the waiter table
`default_nettype none

module lwwt_seq #(
  parameter int NUM_PROCS = lwwt_pkg::NUM_PROCS_DEF,
  localparam int IDX_W = $clog2(NUM_PROCS),
  localparam int CNT_W = $clog2(NUM_PROCS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                start_wake,
  input  logic                start_one,
  input  logic [CNT_W-1:0]    n,
  input  logic                hit,
  input  logic                out_free,
  output lwwt_pkg::scan_ctl_t ctl,
  output logic [IDX_W-1:0]    rd_idx,
  output logic [IDX_W-1:0]    chk_idx
);

  lwwt_pkg::state_t state, state_next;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] last_woken;
  logic [CNT_W-1:0] issued;
  logic             chk_pend;
  logic             mode_one;
  logic             issue_more;

  // next entry in round-robin order, wrapping at the scan limit
  function automatic logic [IDX_W-1:0] rr_next(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    return (inc >= lim) ? '0 : IDX_W'(inc);
  endfunction

  assign issue_more = (issued != n);
  assign rd_idx     = scan_idx;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lwwt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = start_wake ? lwwt_pkg::ST_SCAN : lwwt_pkg::ST_DONE;
        end
      end
      lwwt_pkg::ST_SCAN: begin
        // stop on the first wake-one match, or once the last entry is checked
        if ((chk_pend && hit && mode_one) || !issue_more) begin
          state_next = lwwt_pkg::ST_DONE;
        end
      end
      lwwt_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = lwwt_pkg::ST_IDLE;
        end
      end
      default: state_next = lwwt_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ctl          = '0;
    ctl.wake_one = mode_one;
    unique case (state)
      lwwt_pkg::ST_IDLE: ctl.ready  = 1'b1;
      lwwt_pkg::ST_SCAN: begin
        ctl.issue = issue_more;
        ctl.check = chk_pend;
      end
      lwwt_pkg::ST_DONE: ctl.finish = out_free;
      default: ctl = '0;
    endcase
  end

  // scan pointer, issue count and round-robin position
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lwwt_pkg::ST_IDLE;
      scan_idx   <= '0;
      chk_idx    <= '0;
      last_woken <= '0;
      issued     <= '0;
      chk_pend   <= 1'b0;
      mode_one   <= 1'b0;
    end else begin
      state    <= state_next;
      chk_pend <= ctl.issue;
      if (start && start_wake) begin
        scan_idx <= start_one ? rr_next(last_woken, n) : '0;
        issued   <= '0;
        mode_one <= start_one;
      end
      if (ctl.issue) begin
        scan_idx <= rr_next(scan_idx, n);
        issued   <= issued + CNT_W'(1);
        chk_idx  <= scan_idx;
      end
      if (ctl.check && mode_one) begin
        last_woken <= chk_idx;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/lock_waiter_wakeup_table_top.sv]
// top level of the lock waiter wake-up table
// Usage: each request beat on req (valid/ready) carries one event for the
// per-processor table: start, exit, resume, stop, lock wait, wake one, wake
// all, enter synch or leave synch. Every event gives exactly one response
// beat on rsp (valid/ready) with the woken processor, the end flag and the
// running count after the event.
// Wake one and wake all walk the waiter address memory one entry per cycle
// through a single comparator, n entries where n is active_procs limited
// to 1..NUM_PROCS; wake one stops early when it finds its waiter, and the
// response follows once the scan ends.
// One event at a time: req_ready is high only while the sequencer is idle,
// so a new beat is taken only once the previous event has passed its
// response to the output register.
// A finished response moves into the output register and the next request
// can be taken while it waits; if the receiver stalls, a second response
// holds the sequencer until the output register frees.
// Reset (synchronous, active high) empties the table: no waiters, only
// processor 0 running, count and end flag zero, active_procs 16.
// cfg_we writes active_procs at once; write it only while idle.
`default_nettype none

module lock_waiter_wakeup_table_top #(
  parameter int NUM_PROCS = lwwt_pkg::NUM_PROCS_DEF,
  parameter int ADDR_BITS = lwwt_pkg::ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lwwt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output lwwt_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [4:0]     cfg_data
);

  localparam int IDX_W = $clog2(NUM_PROCS);
  localparam int CNT_W = $clog2(NUM_PROCS + 1);
  localparam int AW    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int NW    = (CNT_W > 5) ? CNT_W : 5;
  localparam int CAP   = (NUM_PROCS < 31) ? NUM_PROCS : 31;

  lwwt_pkg::scan_ctl_t ctl;
  lwwt_pkg::op_t       op;

  logic [4:0]       active_procs;
  logic [NW-1:0]    ap_w;
  logic [CNT_W-1:0] n;

  logic [NUM_PROCS-1:0]      addr_valid;
  logic [NUM_PROCS-1:0]      run_flag;
  logic [NUM_PROCS-1:0]      unstalled_flag;
  logic [NUM_PROCS-1:0][1:0] stall_code;
  logic [4:0]                started_count;
  logic                      end_flag;
  logic                      woke_v;
  logic [3:0]                woke_p;

  logic [AW-1:0]    lock_reg;
  logic [AW-1:0]    lk;
  logic [AW-1:0]    ram_q;
  logic [IDX_W-1:0] pid;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] chk_idx;
  logic             pok;
  logic             start;
  logic             start_wake;
  logic             start_one;
  logic             ram_we;
  logic             hit;
  logic             out_free;

  // request decode
  assign op         = lwwt_pkg::op_t'(req.opcode);
  assign pid        = IDX_W'(req.proc_id);
  assign pok        = {28'd0, req.proc_id} < 32'(NUM_PROCS);
  assign lk         = AW'(req.lock_address);
  assign req_ready  = ctl.ready;
  assign start      = req_valid && ctl.ready;
  assign start_one  = (op == lwwt_pkg::OP_WAKE_ONE);
  assign start_wake = start_one || (op == lwwt_pkg::OP_WAKE_ALL);
  assign ram_we     = start && pok && (op == lwwt_pkg::OP_LOCK_WAIT);
  assign out_free   = !rsp_valid || rsp_ready;

  // scan limit, active_procs held to 1..NUM_PROCS
  assign ap_w = NW'(active_procs);
  assign n    = (ap_w == '0)             ? CNT_W'(1) :
                (ap_w > NW'(NUM_PROCS))  ? CNT_W'(NUM_PROCS) : CNT_W'(ap_w);

  // shared comparator: checked entry against the latched lock address
  assign hit = ctl.check && addr_valid[chk_idx] && (ram_q == lock_reg) &&
               (lock_reg != '0);

  lwwt_seq #(
    .NUM_PROCS(NUM_PROCS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_wake(start_wake),
    .start_one (start_one),
    .n         (n),
    .hit       (hit),
    .out_free  (out_free),
    .ctl       (ctl),
    .rd_idx    (rd_idx),
    .chk_idx   (chk_idx)
  );

  lwwt_ram #(
    .WIDTH(AW),
    .DEPTH(NUM_PROCS)
  ) u_addr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pid),
    .wdata(lk),
    .raddr(rd_idx),
    .rdata(ram_q)
  );

  // latched lock address for the scan
  always_ff @(posedge clk) begin
    if (start) begin
      lock_reg <= lk;
    end
  end

  // per-processor flags, counters and wake result
  always_ff @(posedge clk) begin
    if (rst) begin
      active_procs   <= lwwt_pkg::ACTIVE_PROCS_RST;
      addr_valid     <= '0;
      run_flag       <= NUM_PROCS'(1);
      unstalled_flag <= NUM_PROCS'(1);
      stall_code     <= '0;
      started_count  <= '0;
      end_flag       <= 1'b0;
      woke_v         <= 1'b0;
      woke_p         <= '0;
    end else begin
      if (cfg_we) begin
        active_procs <= cfg_data;
      end
      if (start) begin
        woke_v <= 1'b0;
        woke_p <= '0;
        if (pok) begin
          unique case (op)
            lwwt_pkg::OP_START: begin
              if (started_count < 5'(CAP)) begin
                started_count <= started_count + 5'd1;
              end
              run_flag[pid]       <= 1'b1;
              unstalled_flag[pid] <= 1'b1;
              stall_code[pid]     <= lwwt_pkg::STAT_BUSY;
            end
            lwwt_pkg::OP_EXIT: begin
              if (started_count != 5'd0) begin
                started_count <= started_count - 5'd1;
              end
              run_flag[pid]       <= 1'b0;
              unstalled_flag[pid] <= 1'b0;
              if (req.proc_id == 4'd0) begin
                end_flag <= 1'b1;
              end
            end
            lwwt_pkg::OP_RESUME: begin
              run_flag[pid] <= 1'b1;
              if (stall_code[pid] != lwwt_pkg::STAT_SYNCH) begin
                stall_code[pid] <= lwwt_pkg::STAT_BUSY;
              end
            end
            lwwt_pkg::OP_STOP: begin
              run_flag[pid] <= 1'b0;
              if (stall_code[pid] != lwwt_pkg::STAT_SYNCH) begin
                stall_code[pid] <= req.stop_status;
              end
            end
            lwwt_pkg::OP_LOCK_WAIT: begin
              unstalled_flag[pid] <= 1'b0;
              addr_valid[pid]     <= 1'b1;
            end
            lwwt_pkg::OP_ENTER_SYNCH: stall_code[pid] <= lwwt_pkg::STAT_SYNCH;
            lwwt_pkg::OP_LEAVE_SYNCH: stall_code[pid] <= lwwt_pkg::STAT_BUSY;
            default: ;
          endcase
        end
      end
      // release a matching waiter
      if (hit) begin
        addr_valid[chk_idx]     <= 1'b0;
        unstalled_flag[chk_idx] <= 1'b1;
        if (ctl.wake_one) begin
          woke_v <= 1'b1;
          woke_p <= 4'(chk_idx);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // response beat payload
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      rsp.woke_valid    <= woke_v;
      rsp.woke_proc     <= woke_p;
      rsp.sim_ended     <= end_flag;
      rsp.running_count <= started_count;
    end
  end

endmodule

`default_nettype wire

[rtl/lwwt_checker.sv]
// port-level checker for the lock waiter wake-up table, with its bind
`default_nettype none

`include "lock_waiter_wakeup_table_top_assert.svh"

module lwwt_checker #(
  parameter int NUM_PROCS = lwwt_pkg::NUM_PROCS_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input lwwt_pkg::rsp_t rsp
);

  localparam int CAP = (NUM_PROCS < 31) ? NUM_PROCS : 31;

  // one event at a time: no request beat straight after a taken one
  `LWWT_ASSERT_NEXT(a_req_gap, req_valid && req_ready, !req_ready, "request taken back to back")

  // a stalled response beat stays put
  `LWWT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

  // no processor reported unless one was woken
  `LWWT_ASSERT_NOW(a_woke_zero, rsp_valid && !rsp.woke_valid, rsp.woke_proc == 4'd0, "woke_proc set without wake")

  // running count never passes its cap
  `LWWT_ASSERT_NOW(a_count_cap, rsp_valid, {27'd0, rsp.running_count} <= 32'(CAP), "running count over cap")

endmodule

bind lock_waiter_wakeup_table_top lwwt_checker #(
  .NUM_PROCS(NUM_PROCS)
) u_lwwt_checker (.*);

`default_nettype wire

[dv/testbench.sv]
// self-checking testbench for the lock waiter wake-up table top level
`timescale 1ns / 1ps

module testbench;

  localparam int PROCS = lwwt_pkg::NUM_PROCS_DEF;
  localparam int COUNT_CAP = (PROCS < 31) ? PROCS : 31;
  localparam int ITEMS_PER_SETTING = 78;
  localparam int SETTLE_CYCLES = PROCS + 4;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  lwwt_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  lwwt_pkg::rsp_t rsp;
  logic cfg_we;
  logic [4:0] cfg_data;

  // idling controls shared by the drivers
  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;

  // responses owed by the table, oldest first
  lwwt_pkg::rsp_t status_queue[$];

  // mirrored table state
  logic [31:0] wait_addr [PROCS];
  logic        run_flag [PROCS];
  logic        unstalled [PROCS];
  logic [1:0]  stall_stat [PROCS];
  int          last_woken;
  int          started;
  logic        ended;
  logic [4:0]  active_cfg;

  // lock addresses that waiters and wakers share
  logic [31:0] lock_pool [4];

  lock_waiter_wakeup_table_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #(20_000_000);
    $display("lock_waiter_wakeup_table_top test failed");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    rsp_ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
  end

  // table state after reset
  task automatic model_reset();
    for (int i = 0; i < PROCS; i++) begin
      wait_addr[i] = '0;
      run_flag[i] = 1'b0;
      unstalled[i] = 1'b0;
      stall_stat[i] = lwwt_pkg::STAT_BUSY;
    end
    run_flag[0] = 1'b1;
    unstalled[0] = 1'b1;
    last_woken = 0;
    started = 0;
    ended = 1'b0;
    active_cfg = lwwt_pkg::ACTIVE_PROCS_RST;
  endtask

  // apply one event to the mirrored table and give the response it owes
  function automatic lwwt_pkg::rsp_t table_apply_event(lwwt_pkg::req_t ev);
    lwwt_pkg::rsp_t r;
    int n;
    int p;
    int idx;
    logic [31:0] addr;
    r = '0;
    n = int'(active_cfg);
    if (n < 1) n = 1;
    if (n > PROCS) n = PROCS;
    p = int'(ev.proc_id);
    addr = ev.lock_address;
    case (ev.opcode)
      lwwt_pkg::OP_START: begin
        if (p < PROCS) begin
          if (started < COUNT_CAP) started++;
          run_flag[p] = 1'b1;
          unstalled[p] = 1'b1;
          stall_stat[p] = lwwt_pkg::STAT_BUSY;
        end
      end
      lwwt_pkg::OP_EXIT: begin
        if (p < PROCS) begin
          if (started > 0) started--;
          run_flag[p] = 1'b0;
          unstalled[p] = 1'b0;
          if (p == 0) ended = 1'b1;
        end
      end
      lwwt_pkg::OP_RESUME: begin
        if (p < PROCS) begin
          run_flag[p] = 1'b1;
          if (stall_stat[p] != lwwt_pkg::STAT_SYNCH) stall_stat[p] = lwwt_pkg::STAT_BUSY;
        end
      end
      lwwt_pkg::OP_STOP: begin
        if (p < PROCS) begin
          run_flag[p] = 1'b0;
          if (stall_stat[p] != lwwt_pkg::STAT_SYNCH) stall_stat[p] = ev.stop_status;
        end
      end
      lwwt_pkg::OP_LOCK_WAIT: begin
        if (p < PROCS) begin
          unstalled[p] = 1'b0;
          wait_addr[p] = addr;
        end
      end
      lwwt_pkg::OP_WAKE_ONE: begin
        // round-robin from the entry after the last one woken
        idx = last_woken;
        for (int k = 0; k < n && !r.woke_valid; k++) begin
          idx++;
          if (idx >= n) idx = 0;
          if (addr != '0 && wait_addr[idx] == addr) begin
            unstalled[idx] = 1'b1;
            wait_addr[idx] = '0;
            r.woke_valid = 1'b1;
            r.woke_proc = idx[3:0];
          end
        end
        last_woken = idx;
      end
      lwwt_pkg::OP_WAKE_ALL: begin
        for (int i = 0; i < n; i++) begin
          if (addr != '0 && wait_addr[i] == addr) begin
            unstalled[i] = 1'b1;
            wait_addr[i] = '0;
          end
        end
      end
      lwwt_pkg::OP_ENTER_SYNCH: begin
        if (p < PROCS) stall_stat[p] = lwwt_pkg::STAT_SYNCH;
      end
      lwwt_pkg::OP_LEAVE_SYNCH: begin
        if (p < PROCS) stall_stat[p] = lwwt_pkg::STAT_BUSY;
      end
      default: begin
      end
    endcase
    r.sim_ended = ended;
    r.running_count = started[4:0];
    return r;
  endfunction

  // send one request beat; valid stays high for a following beat
  task automatic send_beat(lwwt_pkg::req_t item);
    while (send_idle_pct > 0 && int'($urandom_range(0, 99)) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req = item;
    do @(posedge clk); while (!req_ready);
    status_queue.push_back(table_apply_event(item));
    @(negedge clk);
  endtask

  task automatic send_event(logic [3:0] op, int proc, logic [1:0] st, logic [31:0] addr);
    lwwt_pkg::req_t item;
    item.opcode = op;
    item.proc_id = proc[3:0];
    item.stop_status = st;
    item.lock_address = addr;
    send_beat(item);
  endtask

  // hold off the sender until every owed response has come back
  task automatic drain_table();
    req_valid = 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_active_procs(logic [4:0] value);
    drain_table();
    cfg_we = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    active_cfg = value;
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 34; recv_stall_pct = 34; end
    endcase
  endtask

  // response checker
  always @(posedge clk) begin
    lwwt_pkg::rsp_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (status_queue.size() == 0) begin
        $display("%0t: response beat with none owed: %p", $time, rsp);
        fail_count++;
      end else begin
        exp_rsp = status_queue.pop_front();
        if (rsp.woke_valid !== exp_rsp.woke_valid || rsp.woke_proc !== exp_rsp.woke_proc ||
            rsp.sim_ended !== exp_rsp.sim_ended ||
            rsp.running_count !== exp_rsp.running_count) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_rsp, rsp);
          fail_count++;
        end
      end
    end
  end

  // start, stop, resume and exit with the counter at its lower limit
  task automatic test_lifecycle();
    send_event(lwwt_pkg::OP_EXIT, 9, 2'd0, 32'h0);
    send_event(lwwt_pkg::OP_START, 3, 2'd0, 32'h0);
    send_event(lwwt_pkg::OP_START, 15, 2'd3, 32'hFFFF_FFFF);
    send_event(lwwt_pkg::OP_STOP, 3, 2'd3, 32'h0);
    send_event(lwwt_pkg::OP_STOP, 15, 2'd2, 32'h0);
    send_event(lwwt_pkg::OP_RESUME, 3, 2'd1, 32'h0);
    send_event(lwwt_pkg::OP_EXIT, 3, 2'd0, 32'h0);
    send_event(lwwt_pkg::OP_EXIT, 15, 2'd0, 32'h0);
  endtask

  // synch status survives stop and resume
  task automatic test_synch_sticky();
    send_event(lwwt_pkg::OP_ENTER_SYNCH, 5, 2'd0, 32'h0);
    send_event(lwwt_pkg::OP_STOP, 5, 2'd3, 32'h0);
    send_event(lwwt_pkg::OP_RESUME, 5, 2'd0, 32'h0);
    send_event(lwwt_pkg::OP_LEAVE_SYNCH, 5, 2'd0, 32'h0);
    send_event(lwwt_pkg::OP_STOP, 5, 2'd1, 32'h0);
    send_event(lwwt_pkg::OP_RESUME, 5, 2'd0, 32'h0);
  endtask

  // waits and wakes, address zero never matching
  task automatic test_lock_wake();
    send_event(lwwt_pkg::OP_LOCK_WAIT, 1, 2'd0, 32'hFFFF_FFFF);
    send_event(lwwt_pkg::OP_LOCK_WAIT, 2, 2'd0, 32'hFFFF_FFFF);
    send_event(lwwt_pkg::OP_LOCK_WAIT, 4, 2'd0, 32'h0);
    send_event(lwwt_pkg::OP_WAKE_ONE, 0, 2'd0, 32'h0);
    send_event(lwwt_pkg::OP_WAKE_ALL, 0, 2'd0, 32'h0);
    send_event(lwwt_pkg::OP_WAKE_ONE, 0, 2'd0, 32'hFFFF_FFFF);
    send_event(lwwt_pkg::OP_WAKE_ONE, 0, 2'd0, 32'hFFFF_FFFF);
    send_event(lwwt_pkg::OP_WAKE_ONE, 0, 2'd0, 32'hFFFF_FFFF);
    send_event(lwwt_pkg::OP_LOCK_WAIT, 0, 2'd0, 32'h5A5A_0001);
    send_event(lwwt_pkg::OP_LOCK_WAIT, 7, 2'd0, 32'h5A5A_0001);
    send_event(lwwt_pkg::OP_WAKE_ALL, 0, 2'd0, 32'h5A5A_0001);
  endtask

  // undefined event codes leave the table alone
  task automatic test_unknown_codes();
    send_event(4'd9, 2, 2'd3, 32'hFFFF_FFFF);
    send_event(4'd12, 7, 2'd1, 32'h1234_5678);
    send_event(4'd15, 15, 2'd2, 32'h0);
  endtask

  // random event with mostly meaningful content
  function automatic lwwt_pkg::req_t random_event();
    lwwt_pkg::req_t ev;
    int pick;
    ev.opcode = 4'($urandom_range(0, 15));
    ev.proc_id = 4'($urandom_range(0, 15));
    ev.stop_status = 2'($urandom_range(0, 3));
    ev.lock_address = $urandom;
    pick = int'($urandom_range(0, 99));
    if (pick < 15) ev.opcode = lwwt_pkg::OP_START;
    else if (pick < 25) begin
      ev.opcode = lwwt_pkg::OP_EXIT;
      ev.proc_id = 4'($urandom_range(1, 15));
    end
    else if (pick < 33) ev.opcode = lwwt_pkg::OP_RESUME;
    else if (pick < 43) ev.opcode = lwwt_pkg::OP_STOP;
    else if (pick < 58) ev.opcode = lwwt_pkg::OP_LOCK_WAIT;
    else if (pick < 73) ev.opcode = lwwt_pkg::OP_WAKE_ONE;
    else if (pick < 81) ev.opcode = lwwt_pkg::OP_WAKE_ALL;
    else if (pick < 87) ev.opcode = lwwt_pkg::OP_ENTER_SYNCH;
    else if (pick < 92) ev.opcode = lwwt_pkg::OP_LEAVE_SYNCH;
    else if (pick < 96) ev.opcode = 4'($urandom_range(9, 15));
    // waits and wakes mostly share a small set of locks
    if (ev.opcode inside {lwwt_pkg::OP_LOCK_WAIT, lwwt_pkg::OP_WAKE_ONE,
                          lwwt_pkg::OP_WAKE_ALL}) begin
      pick = int'($urandom_range(0, 9));
      if (pick < 8) ev.lock_address = lock_pool[2'($urandom_range(0, 3))];
      else if (pick == 8) ev.lock_address = '0;
    end
    // processor 0 exits only in the end-flag test
    if (ev.opcode == lwwt_pkg::OP_EXIT && ev.proc_id == 4'd0) ev.proc_id = 4'd1;
    return ev;
  endfunction

  // random traffic across scan sizes and idling phases
  task automatic test_random_traffic();
    logic [4:0] cfg_plan [9];
    cfg_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd5, 5'd16, 5'd16};
    cfg_plan[7] = 5'($urandom_range(1, 16));
    lock_pool[0] = 32'hFFFF_FFFF;
    lock_pool[1] = $urandom | 32'h1;
    lock_pool[2] = $urandom | 32'h8000_0000;
    lock_pool[3] = $urandom_range(1, 255);
    for (int s = 0; s < 9; s++) begin
      write_active_procs(cfg_plan[s]);
      set_idling(s);
      for (int k = 0; k < ITEMS_PER_SETTING; k++) send_beat(random_event());
    end
    drain_table();
    set_idling(0);
  endtask

  // exit of processor 0 raises the end flag for good
  task automatic test_end_flag();
    set_idling(3);
    send_event(lwwt_pkg::OP_EXIT, 0, 2'd0, 32'h0);
    send_event(lwwt_pkg::OP_START, 0, 2'd0, 32'h0);
    for (int k = 0; k < 12; k++) send_beat(random_event());
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    set_idling(0);
    model_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_lifecycle();
    test_synch_sticky();
    test_lock_wake();
    test_unknown_codes();
    test_random_traffic();
    test_end_flag();

    drain_table();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("lock_waiter_wakeup_table_top test passed");
    end else begin
      $display("lock_waiter_wakeup_table_top test failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/lwwt_pkg.sv
rtl/lwwt_ram.sv
rtl/lwwt_seq.sv
rtl/lock_waiter_wakeup_table_top.sv
rtl/lwwt_checker.sv
dv/testbench.sv
